// ===== rtl/fbhh_pkg.sv =====
// ----------------------------------------------------------------------------
// fbhh_pkg
// Shared types and constants for the flow byte heavy-hitter table.
// ----------------------------------------------------------------------------
package fbhh_pkg;

	localparam int unsigned DEFAULT_ENTRIES = 256;

	localparam logic [15:0] ETHER_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] LEN_ETH    = 16'd14;
	localparam logic [15:0] LEN_IP     = 16'd34;
	localparam logic [15:0] LEN_UDP    = 16'd42;
	localparam logic [15:0] LEN_TCP    = 16'd54;

	localparam logic [31:0] LIMIT_RESET = 32'd1024;
	localparam logic [31:0] MASK_RESET  = 32'hFFFF_FFF0;

	localparam logic [0:0] REG_BYTE_LIMIT = 1'b0;
	localparam logic [0:0] REG_SRC_MASK   = 1'b1;

	localparam logic [1:0] VERDICT_DROP  = 2'd0;
	localparam logic [1:0] VERDICT_UNDER = 2'd1;
	localparam logic [1:0] VERDICT_OVER  = 2'd2;

	typedef struct packed {
		logic [63:0] kaddr;
		logic [39:0] kpp;
		logic [15:0] len;
		logic        fin;
	} fbhh_req_t;

	// Token that travels down the chain with a lookup.
	typedef struct packed {
		logic        hit;
		logic        placed;
		logic        removed;
		logic [63:0] total;
	} fbhh_tok_t;

endpackage

// ===== rtl/fbhh_cell.sv =====
// ----------------------------------------------------------------------------
// fbhh_cell
// One table entry. Claims the request when its key matches, or when it is free,
// the request has no FIN and no earlier entry has claimed it; passes the result on.
// ----------------------------------------------------------------------------
module fbhh_cell
	import fbhh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld_in,
	input  fbhh_req_t req_in,
	input  fbhh_tok_t tok_in,
	input  logic      commit,
	output logic      vld_out,
	output fbhh_req_t req_out,
	output fbhh_tok_t tok_out
);

	logic        valid_q;
	logic        pend_q;
	logic [63:0] kaddr_q;
	logic [39:0] kpp_q;
	logic [63:0] count_q;
	logic        match;
	logic        take;
	logic [63:0] sum;
	fbhh_tok_t   tok_nxt;

	// A free entry only reserves itself on the way down. A matching entry may
	// still sit further along the chain, so the entry becomes valid only when
	// the request leaves the chain without a hit.
	assign match = valid_q && kaddr_q == req_in.kaddr && kpp_q == req_in.kpp;
	assign take  = !valid_q && !tok_in.placed && !req_in.fin;
	assign sum   = count_q + {48'd0, req_in.len};

	always_comb begin
		tok_nxt = tok_in;
		if (match && !tok_in.hit) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.total   = sum;
			tok_nxt.removed = req_in.fin;
		end
		if (take)
			tok_nxt.placed = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
			if (vld_in) begin
				pend_q <= take && !tok_in.hit;
				if (match && !tok_in.hit && req_in.fin)
					valid_q <= 1'b0;
			end else if (commit && pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_out <= req_in;
		tok_out <= tok_nxt;
		if (vld_in) begin
			if (match && !tok_in.hit)
				count_q <= sum;
			else if (take && !tok_in.hit) begin
				kaddr_q <= req_in.kaddr;
				kpp_q   <= req_in.kpp;
				count_q <= {48'd0, req_in.len};
			end
		end
	end

endmodule

// ===== rtl/flow_byte_heavy_hitter_table_unit.sv =====
// ----------------------------------------------------------------------------
// flow_byte_heavy_hitter_table_unit
// Exact-match flow table that counts bytes per five-tuple.
// ----------------------------------------------------------------------------
// The table is a chain of TABLE_ENTRIES cells; a packet visits one cell per
// cycle and may not enter until the previous packet has left the chain. A
// packet that reaches the table passes the in_vld_s1 input register, every
// cell register and then the done register, and a new entry becomes valid as
// the packet leaves the chain. Dropped packets skip the chain and raise done
// through the drop_pend_q register. busy is high from the accepting edge
// through the done cycle, so the next transfer is accepted only after done.
// Results appear for one cycle on done and cannot be held off by the receiver.
module flow_byte_heavy_hitter_table_unit
	import fbhh_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = DEFAULT_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] packet_length,
	input  logic [15:0] ether_type,
	input  logic [7:0]  ip_protocol,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic        tcp_fin,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [1:0]  verdict,
	output logic [63:0] flow_total,
	output logic        table_hit,
	output logic        entry_inserted,
	output logic        entry_removed
);

	logic [31:0] limit_q;
	logic [31:0] mask_q;
	logic        drop;
	logic        fin_eff;
	logic        busy_q;
	logic        drop_pend_q;
	logic        commit;
	logic        in_vld_s1;
	fbhh_req_t   in_req_s1;

	logic      vld_c [TABLE_ENTRIES+1];
	fbhh_req_t req_c [TABLE_ENTRIES+1];
	fbhh_tok_t tok_c [TABLE_ENTRIES+1];

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	always_comb begin
		drop    = 1'b0;
		fin_eff = tcp_fin;
		if (packet_length < LEN_ETH || ether_type != ETHER_IPV4 || packet_length < LEN_IP)
			drop = 1'b1;
		else if (ip_protocol == PROTO_UDP) begin
			drop    = packet_length < LEN_UDP;
			fin_eff = 1'b0;
		end else if (ip_protocol == PROTO_TCP)
			drop = packet_length < LEN_TCP;
		else
			drop = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			mask_q    <= MASK_RESET;
			busy_q    <= 1'b0;
			in_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BYTE_LIMIT: limit_q <= cfg_data;
					REG_SRC_MASK:   mask_q  <= cfg_data;
					default:        ;
				endcase
			end
			in_vld_s1 <= start && !busy_q && !drop;
			done      <= vld_c[TABLE_ENTRIES] || drop_pend_q;
			if (start && !busy_q)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;
		end
	end

	// Dropped packets skip the chain; a one-shot delay stands in for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			drop_pend_q <= 1'b0;
		else
			drop_pend_q <= start && !busy_q && drop;
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			in_req_s1.kaddr <= {source_address & mask_q, dest_address};
			in_req_s1.kpp   <= {ip_protocol, source_port, dest_port};
			in_req_s1.len   <= packet_length;
			in_req_s1.fin   <= fin_eff;
		end
	end

	assign vld_c[0] = in_vld_s1;
	assign req_c[0] = in_req_s1;
	assign tok_c[0] = '{hit: 1'b0, placed: 1'b0, removed: 1'b0,
		total: {48'd0, in_req_s1.len}};

	assign commit = vld_c[TABLE_ENTRIES] && !tok_c[TABLE_ENTRIES].hit
		&& tok_c[TABLE_ENTRIES].placed;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		fbhh_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[g]),
			.req_in  (req_c[g]),
			.tok_in  (tok_c[g]),
			.commit  (commit),
			.vld_out (vld_c[g+1]),
			.req_out (req_c[g+1]),
			.tok_out (tok_c[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (vld_c[TABLE_ENTRIES]) begin
			verdict        <= (tok_c[TABLE_ENTRIES].total < {32'd0, limit_q})
				? VERDICT_UNDER : VERDICT_OVER;
			flow_total     <= tok_c[TABLE_ENTRIES].total;
			table_hit      <= tok_c[TABLE_ENTRIES].hit;
			entry_inserted <= !tok_c[TABLE_ENTRIES].hit && tok_c[TABLE_ENTRIES].placed;
			entry_removed  <= tok_c[TABLE_ENTRIES].removed;
		end else if (drop_pend_q) begin
			verdict        <= VERDICT_DROP;
			flow_total     <= 64'd0;
			table_hit      <= 1'b0;
			entry_inserted <= 1'b0;
			entry_removed  <= 1'b0;
		end
	end

endmodule

// ===== rtl/fbhh_checker.sv =====
// ----------------------------------------------------------------------------
// fbhh_checker
// Port-level checks on the flow table, bound to the top level.
// ----------------------------------------------------------------------------
module fbhh_checker
	import fbhh_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  verdict,
	input logic [63:0] flow_total,
	input logic        table_hit,
	input logic        entry_inserted,
	input logic        entry_removed
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a transfer");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && verdict == VERDICT_DROP |-> flow_total == 64'd0 && !table_hit
			&& !entry_inserted && !entry_removed) else $error("dropped result not empty");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(table_hit && entry_inserted) && !(entry_removed && !table_hit))
		else $error("inconsistent table flags");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy held after result");

endmodule

bind flow_byte_heavy_hitter_table_unit fbhh_checker u_fbhh_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.verdict        (verdict),
	.flow_total     (flow_total),
	.table_hit      (table_hit),
	.entry_inserted (entry_inserted),
	.entry_removed  (entry_removed)
);

// ===== test/flow_byte_heavy_hitter_table_unit_tb.sv =====
// ----------------------------------------------------------------------------
// flow_byte_heavy_hitter_table_unit_tb
// Self-checking testbench for the flow byte heavy-hitter table. Packets are
// driven through the start/busy command port, and each transfer is run through
// a flow table predictor. Every done strobe is checked field by field against
// the oldest predicted result. Directed packets cover the truncation and drop
// cases, FIN handling and the register extremes. Random phases use small flow
// pools, noise packets, and one pass that fills the table.
// ----------------------------------------------------------------------------
module flow_byte_heavy_hitter_table_unit_tb;
	import fbhh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENTRIES     = DEFAULT_ENTRIES;
	localparam int unsigned LATENCY     = ENTRIES + 2;
	localparam longint      CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [15:0] len;
		logic [15:0] etype;
		logic [7:0]  proto;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        fin;
	} packet_t;

	typedef struct {
		logic [1:0]  verdict;
		logic [63:0] total;
		logic        hit;
		logic        inserted;
		logic        removed;
	} flow_result_t;

	class flow_scoreboard;
		logic [31:0]  limit;
		logic [31:0]  mask;
		logic [63:0]  addr_keys [ENTRIES];
		logic [39:0]  port_keys [ENTRIES];
		logic [63:0]  counts [ENTRIES];
		bit           valid [ENTRIES];
		flow_result_t pending_results [$];
		int           errors;
		int           n_hits;
		int           n_inserts;
		int           n_removes;
		int           n_drops;
		int           n_checked;

		function new();
			limit = LIMIT_RESET;
			mask = MASK_RESET;
			foreach (valid[i]) valid[i] = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [31:0] data);
			if (idx == REG_BYTE_LIMIT) limit = data;
			else mask = data;
		endfunction

		function void note_packet(packet_t p);
			flow_result_t r;
			bit drop;
			bit fin;
			logic [63:0] ka;
			logic [39:0] kp;
			int match;
			int free_slot;
			drop = 0;
			fin = p.fin;
			r = '{VERDICT_DROP, 64'd0, 1'b0, 1'b0, 1'b0};
			if (p.len < LEN_ETH || p.etype != ETHER_IPV4 || p.len < LEN_IP) drop = 1;
			else if (p.proto == PROTO_UDP) begin
				if (p.len < LEN_UDP) drop = 1;
				fin = 0;
			end else if (p.proto == PROTO_TCP) begin
				if (p.len < LEN_TCP) drop = 1;
			end else drop = 1;
			if (drop) begin
				n_drops++;
				pending_results.push_back(r);
				return;
			end
			ka = {p.saddr & mask, p.daddr};
			kp = {p.proto, p.sport, p.dport};
			match = -1;
			free_slot = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid[i]) begin
					if (match < 0 && addr_keys[i] == ka && port_keys[i] == kp) match = i;
				end else if (free_slot < 0) free_slot = i;
			end
			r.total = {48'd0, p.len};
			if (match >= 0) begin
				r.hit = 1;
				counts[match] += {48'd0, p.len};
				r.total = counts[match];
				if (fin) begin
					valid[match] = 0;
					r.removed = 1;
				end
			end else if (!fin && free_slot >= 0) begin
				addr_keys[free_slot] = ka;
				port_keys[free_slot] = kp;
				counts[free_slot] = {48'd0, p.len};
				valid[free_slot] = 1;
				r.inserted = 1;
			end
			r.verdict = (r.total < {32'd0, limit}) ? VERDICT_UNDER : VERDICT_OVER;
			n_hits += r.hit;
			n_inserts += r.inserted;
			n_removes += r.removed;
			pending_results.push_back(r);
		endfunction

		function void check_result(flow_result_t a);
			flow_result_t e;
			if (pending_results.size() == 0) begin
				$error("result with no packet outstanding");
				errors++;
				return;
			end
			e = pending_results.pop_front();
			n_checked++;
			if (a.verdict !== e.verdict) begin
				$error("verdict: expected %0d, got %0d", e.verdict, a.verdict);
				errors++;
			end
			if (a.total !== e.total) begin
				$error("flow_total: expected %0d, got %0d", e.total, a.total);
				errors++;
			end
			if (a.hit !== e.hit) begin
				$error("table_hit: expected %0b, got %0b", e.hit, a.hit);
				errors++;
			end
			if (a.inserted !== e.inserted) begin
				$error("entry_inserted: expected %0b, got %0b", e.inserted, a.inserted);
				errors++;
			end
			if (a.removed !== e.removed) begin
				$error("entry_removed: expected %0b, got %0b", e.removed, a.removed);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] packet_length;
	logic [15:0] ether_type;
	logic [7:0]  ip_protocol;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic        tcp_fin;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [1:0]  verdict;
	logic [63:0] flow_total;
	logic        table_hit;
	logic        entry_inserted;
	logic        entry_removed;

	flow_scoreboard sb;
	longint cycles;
	packet_t flows [16];

	flow_byte_heavy_hitter_table_unit dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("flow_byte_heavy_hitter_table_unit test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{verdict, flow_total, table_hit, entry_inserted, entry_removed});
	end

	task automatic idle_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return;
		else if (roll < 93) repeat ($urandom_range(1, 5)) @(posedge clk);
		else repeat ($urandom_range(20, 300)) @(posedge clk);
	endtask

	task automatic send_packet(packet_t p);
		idle_gap();
		start <= 1'b1;
		packet_length <= p.len;
		ether_type <= p.etype;
		ip_protocol <= p.proto;
		source_address <= p.saddr;
		dest_address <= p.daddr;
		source_port <= p.sport;
		dest_port <= p.dport;
		tcp_fin <= p.fin;
		do @(posedge clk); while (busy);
		sb.note_packet(p);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending_results.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic packet_t make_flow();
		packet_t p;
		p.len = 16'd64;
		p.etype = ETHER_IPV4;
		p.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
		p.saddr = $urandom();
		p.daddr = $urandom();
		p.sport = 16'($urandom());
		p.dport = 16'($urandom());
		p.fin = 1'b0;
		return p;
	endfunction

	task automatic new_pool();
		foreach (flows[i]) flows[i] = make_flow();
	endtask

	function automatic packet_t random_packet();
		packet_t p;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			p.len = 16'($urandom());
			p.etype = $urandom_range(0, 3) == 0 ? ETHER_IPV4 : 16'($urandom());
			p.proto = $urandom_range(0, 2) == 0 ? 8'($urandom()) : PROTO_TCP;
			p.saddr = $urandom();
			p.daddr = $urandom();
			p.sport = 16'($urandom());
			p.dport = 16'($urandom());
			p.fin = 1'($urandom());
			return p;
		end
		p = flows[$urandom_range(0, 15)];
		if (roll < 18) p.saddr[3:0] = 4'($urandom());
		if (roll < 22) p.len = 16'($urandom_range(0, 60));
		else if (roll < 25) p.len = 16'($urandom());
		else p.len = 16'($urandom_range(54, 1600));
		p.fin = $urandom_range(0, 9) == 0;
		return p;
	endfunction

	task automatic random_phase(int n);
		new_pool();
		repeat (n) send_packet(random_packet());
	endtask

	initial begin
		packet_t p;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		packet_length = '0;
		ether_type = '0;
		ip_protocol = '0;
		source_address = '0;
		dest_address = '0;
		source_port = '0;
		dest_port = '0;
		tcp_fin = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: truncation boundaries, drops, hits, FIN and extremes.
		p = make_flow();
		p.proto = PROTO_TCP;
		p.len = 16'd13;  send_packet(p);
		p.len = 16'd33;  send_packet(p);
		p.len = 16'd53;  send_packet(p);
		p.len = 16'd54;  send_packet(p);
		p.len = 16'd1000; send_packet(p);
		p.saddr[3:0] = ~p.saddr[3:0]; send_packet(p);
		p.fin = 1'b1;    send_packet(p);
		send_packet(p);
		p.fin = 1'b0; p.len = 16'hFFFF; send_packet(p);
		p.etype = 16'h86DD; send_packet(p);
		p.etype = 16'hFFFF; p.len = 16'd0; send_packet(p);
		p = make_flow();
		p.proto = PROTO_UDP;
		p.len = 16'd41;  send_packet(p);
		p.len = 16'd42;  send_packet(p);
		p.fin = 1'b1;    send_packet(p);
		p.proto = 8'hFF; send_packet(p);
		p.proto = 8'd1;  p.len = 16'hFFFF; send_packet(p);
		p = '{16'hFFFF, ETHER_IPV4, PROTO_TCP, '1, '1, '1, '1, 1'b0};
		send_packet(p);
		p = '{16'd54, ETHER_IPV4, PROTO_TCP, '0, '0, '0, '0, 1'b0};
		send_packet(p);

		write_reg(REG_BYTE_LIMIT, 32'd0);
		write_reg(REG_SRC_MASK, 32'hFFFF_FFFF);
		random_phase(350);
		write_reg(REG_BYTE_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_SRC_MASK, 32'd0);
		random_phase(350);

		// Fill the table past capacity with distinct flows.
		write_reg(REG_BYTE_LIMIT, 32'd3000);
		write_reg(REG_SRC_MASK, 32'hF0FF_FFFF);
		for (int i = 0; i < ENTRIES + 40; i++) begin
			p = make_flow();
			p.len = 16'($urandom_range(54, 1500));
			send_packet(p);
		end
		random_phase(150);
		write_reg(REG_BYTE_LIMIT, 32'd1 << 10);
		write_reg(REG_SRC_MASK, $urandom());
		random_phase(350);

		drain();
		repeat (LATENCY + 20) @(posedge clk);
		$display("Checked %0d results: %0d drops, %0d hits, %0d inserts, %0d FIN removals.",
			sb.n_checked, sb.n_drops, sb.n_hits, sb.n_inserts, sb.n_removes);
		$display("Covered truncation limits, register extremes and a full table.");
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("flow_byte_heavy_hitter_table_unit test passed");
		end else begin
			$display("flow_byte_heavy_hitter_table_unit test failed");
		end
		$finish;
	end

endmodule
